/* hdl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg: shell line tokenizer shared definitions
// Token kinds, character codes and the token record used by the tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

   localparam int unsigned TOKEN_BITS = 16;

   // token kinds
   localparam logic [2:0] KIND_WORD    = 3'd0;
   localparam logic [2:0] KIND_OPER    = 3'd1;
   localparam logic [2:0] KIND_QUOTE   = 3'd2;
   localparam logic [2:0] KIND_NEWLINE = 3'd3;
   localparam logic [2:0] KIND_COMMENT = 3'd4;

   // character codes
   localparam logic [7:0] CHAR_PIPE      = 8'h7C;
   localparam logic [7:0] CHAR_AMP       = 8'h26;
   localparam logic [7:0] CHAR_LESS      = 8'h3C;
   localparam logic [7:0] CHAR_GREATER   = 8'h3E;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_BACKTICK  = 8'h60;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_VTAB      = 8'h0B;
   localparam logic [7:0] CHAR_FORMFEED  = 8'h0C;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;

   typedef struct packed {
      logic [2:0]            token_kind;
      logic [TOKEN_BITS-1:0] token_start;
      logic [TOKEN_BITS-1:0] token_length;
      logic                  last_of_run;
   } token_type;

endpackage

/* hdl/slt_req_if.sv */
// ----------------------------------------------------------------------------
// slt_req_if: character request channel
// Carries one line byte and its end-of-line flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface slt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_line;

   modport source (output valid, output char_code, output end_of_line, input ready);
   modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

/* hdl/slt_rsp_if.sv */
// ----------------------------------------------------------------------------
// slt_rsp_if: token result channel
// Carries one token record with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface slt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input last_of_run, output ready);
endinterface

/* hdl/shell_line_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// shell_line_tokenizer_unit: shell command line tokenizer
// Scans one byte per request and emits word, operator, quote, newline and
// comment tokens as kind, start position and length.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                        handshake
//  req_chan  in         char_code, end_of_line                         valid/ready
//  rsp_chan  out        token_kind, token_start, token_length,         valid/ready
//                       last_of_run
//
// One byte is taken per cycle while the queue has room; its tokens (zero to
// two) are written into a four-entry result queue in the same cycle and leave
// one per cycle while rsp ready is high. req ready is high while the queue
// holds two entries or fewer.
// Synchronous reset clears the scan state and empties the queue.
// A stalled rsp side fills the queue and then holds off requests.
// ----------------------------------------------------------------------------
module shell_line_tokenizer_unit
   import slt_pkg::*;
#(
   parameter int unsigned POSITION_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   slt_req_if.sink      req_chan,
   slt_rsp_if.source    rsp_chan
);

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_WORD    = 2'd1;
   localparam logic [1:0] MODE_QUOTE   = 2'd2;
   localparam logic [1:0] MODE_COMMENT = 2'd3;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_BITS   = 2;

   localparam logic [POSITION_BITS-1:0] POS_TOP = '1;

   logic [1:0]               mode_ff, mode_in;
   logic [7:0]               quote_ff, quote_in;
   logic [7:0]               prev_ff, prev_in;
   logic [POSITION_BITS-1:0] begin_ff, begin_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   token_type                tok [2];
   logic [1:0]               tok_count;

   token_type                queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]     head_ff, tail_ff;
   logic [QPTR_BITS:0]       count_ff;

   logic                     push, pop;
   logic [7:0]               c;
   logic                     is_op, is_blank, is_term;

   function automatic logic [TOKEN_BITS-1:0] fit_pos(input logic [POSITION_BITS-1:0] p);
      return TOKEN_BITS'(32'(p));
   endfunction

   // saturated span length, never zero
   function automatic logic [TOKEN_BITS-1:0] span_len(
      input logic [POSITION_BITS-1:0] b,
      input logic [POSITION_BITS-1:0] e,
      input logic                     extra
   );
      logic [POSITION_BITS:0] len;
      len = {1'b0, e} - {1'b0, b} + (POSITION_BITS+1)'(extra);
      if (len > {1'b0, POS_TOP}) len = {1'b0, POS_TOP};
      if (len == '0) len = (POSITION_BITS+1)'(1);
      return TOKEN_BITS'(32'(len[POSITION_BITS-1:0]));
   endfunction

   assign c        = req_chan.char_code;
   assign is_op    = c inside {CHAR_PIPE, CHAR_AMP, CHAR_LESS, CHAR_GREATER};
   assign is_blank = c inside {CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, CHAR_VTAB,
                               CHAR_FORMFEED, CHAR_RETURN};
   assign is_term  = is_op || is_blank || (c == CHAR_HASH);

   assign push = req_chan.valid && req_chan.ready;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      token_type t;
      logic      idle_pass;
      t         = '0;
      idle_pass = 1'b0;
      tok[0]    = '0;
      tok[1]    = '0;
      tok_count = 2'd0;
      mode_in   = mode_ff;
      quote_in  = quote_ff;
      begin_in  = begin_ff;

      case (mode_ff)
         MODE_WORD: begin
            if (is_term) begin
               t = '{KIND_WORD, fit_pos(begin_ff), span_len(begin_ff, pos_ff, 1'b0), 1'b0};
               tok[tok_count[0]] = t;
               tok_count = tok_count + 2'd1;
               mode_in   = MODE_IDLE;
               idle_pass = 1'b1;
            end
         end
         MODE_QUOTE: begin
            if (c == quote_ff && prev_ff != CHAR_BACKSLASH) begin
               t = '{KIND_QUOTE, fit_pos(begin_ff), span_len(begin_ff, pos_ff, 1'b1), 1'b0};
               tok[tok_count[0]] = t;
               tok_count = tok_count + 2'd1;
               mode_in   = MODE_IDLE;
            end
         end
         MODE_IDLE: begin
            idle_pass = 1'b1;
         end
         default: begin
         end
      endcase

      // byte that ended a word is looked at again as in idle
      if (idle_pass) begin
         if (is_op) begin
            t = '{KIND_OPER, fit_pos(pos_ff), TOKEN_BITS'(1), 1'b0};
            tok[tok_count[0]] = t;
            tok_count = tok_count + 2'd1;
         end else if (is_blank) begin
            if (c == CHAR_NEWLINE) begin
               t = '{KIND_NEWLINE, fit_pos(pos_ff), TOKEN_BITS'(1), 1'b0};
               tok[tok_count[0]] = t;
               tok_count = tok_count + 2'd1;
            end
         end else if (c == CHAR_HASH) begin
            begin_in = pos_ff;
            mode_in  = MODE_COMMENT;
         end else if (c inside {CHAR_SQUOTE, CHAR_DQUOTE, CHAR_BACKTICK}) begin
            quote_in = c;
            begin_in = pos_ff;
            mode_in  = MODE_QUOTE;
         end else begin
            begin_in = pos_ff;
            mode_in  = MODE_WORD;
         end
      end

      // flush an open word or comment at end of line, drop an open quote
      if (req_chan.end_of_line) begin
         if (mode_in == MODE_WORD) begin
            t = '{KIND_WORD, fit_pos(begin_in), span_len(begin_in, pos_ff, 1'b1), 1'b0};
            tok[tok_count[0]] = t;
            tok_count = tok_count + 2'd1;
         end else if (mode_in == MODE_COMMENT) begin
            t = '{KIND_COMMENT, fit_pos(begin_in), span_len(begin_in, pos_ff, 1'b1), 1'b0};
            tok[tok_count[0]] = t;
            tok_count = tok_count + 2'd1;
         end
         mode_in  = MODE_IDLE;
         quote_in = 8'h00;
         begin_in = '0;
         prev_in  = 8'h00;
         pos_in   = '0;
      end else begin
         prev_in = c;
         pos_in  = (pos_ff == POS_TOP) ? pos_ff : pos_ff + POSITION_BITS'(1);
      end

      if (tok_count == 2'd2)      tok[1].last_of_run = 1'b1;
      else if (tok_count == 2'd1) tok[0].last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         quote_ff <= 8'h00;
         prev_ff  <= 8'h00;
         begin_ff <= '0;
         pos_ff   <= '0;
      end else if (push) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         prev_ff  <= prev_in;
         begin_ff <= begin_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) tail_ff <= tail_ff + QPTR_BITS'(tok_count);
         if (pop)  head_ff <= head_ff + QPTR_BITS'(1);
         count_ff <= count_ff + ((QPTR_BITS+1)'(push ? tok_count : 2'd0))
                             - (QPTR_BITS+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push && tok_count != 2'd0) queue_ff[tail_ff] <= tok[0];
      if (push && tok_count == 2'd2) queue_ff[tail_ff + QPTR_BITS'(1)] <= tok[1];
   end

   assign req_chan.ready = (count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2));

   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.token_kind   = queue_ff[head_ff].token_kind;
   assign rsp_chan.token_start  = queue_ff[head_ff].token_start;
   assign rsp_chan.token_length = queue_ff[head_ff].token_length;
   assign rsp_chan.last_of_run  = queue_ff[head_ff].last_of_run;

endmodule

/* test/tb_shell_line_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// tb: shell line tokenizer unit testbench
// Feeds command line bytes through the request channel, takes each expected
// token from the directed table or a behavioral scanner and compares the
// token stream field by field. Covers a directed table, random lines with
// idling on both sides and a final stretch with no idling.
// ----------------------------------------------------------------------------
module tb;
   import slt_pkg::*;

   localparam int unsigned POS_BITS   = 16;
   localparam logic [31:0] POS_TOP    = (32'd1 << POS_BITS) - 32'd1;
   localparam int          QUIET_MAX  = 2000;
   localparam int          DRAIN_WAIT = 16;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_WORD,
      SCAN_QUOTE,
      SCAN_COMMENT
   } scan_mode_type;

   typedef struct {
      logic [7:0] char_code;
      logic       end_of_line;
      bit         typed;
      int         count;
      token_type  tok0;
      token_type  tok1;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slt_req_if req_if ();
   slt_rsp_if rsp_if ();

   shell_line_tokenizer_unit #(
      .POSITION_BITS(POS_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scanner state
   scan_mode_type mode_q;
   logic [7:0]  quote_q;
   logic [7:0]  prev_q;
   logic [15:0] begin_q;
   logic [15:0] pos_q;

   token_type   run_tokens[$];
   token_type   expected_tokens[$];
   logic [7:0]  line_bytes[$];

   bit idling;
   int stall_left;
   int quiet_cycles;
   int fail_count;
   int sent_count;

   function automatic bit is_oper(input logic [7:0] c);
      return c == CHAR_PIPE || c == CHAR_AMP || c == CHAR_LESS || c == CHAR_GREATER;
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NEWLINE || c == CHAR_VTAB ||
             c == CHAR_FORMFEED || c == CHAR_RETURN;
   endfunction

   function automatic bit is_quote(input logic [7:0] c);
      return c == CHAR_SQUOTE || c == CHAR_DQUOTE || c == CHAR_BACKTICK;
   endfunction

   function automatic token_type tok(input logic [2:0] kind, input logic [15:0] start,
                                     input logic [15:0] len, input logic last);
      token_type t;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = len;
      t.last_of_run  = last;
      return t;
   endfunction

   // length from saturated positions, clamped to the top value and never zero
   function automatic logic [15:0] span(input logic [15:0] b, input logic [15:0] e,
                                        input logic [31:0] extra);
      logic [31:0] len;
      len = ((e >= b) ? 32'(e) - 32'(b) : 32'd0) + extra;
      if (len > POS_TOP)
         len = POS_TOP;
      if (len == 32'd0)
         len = 32'd1;
      return len[15:0];
   endfunction

   function automatic void clear_scan();
      mode_q  = SCAN_IDLE;
      quote_q = 8'd0;
      prev_q  = 8'd0;
      begin_q = 16'd0;
      pos_q   = 16'd0;
   endfunction

   // tokens caused by one byte go to run_tokens
   function automatic void scan_byte(input logic [7:0] c, input logic eol);
      logic [15:0] pos;
      pos = pos_q;
      run_tokens.delete();
      if (mode_q == SCAN_WORD && (is_blank(c) || is_oper(c) || c == CHAR_HASH)) begin
         run_tokens.push_back(tok(KIND_WORD, begin_q, span(begin_q, pos, 0), 1'b0));
         mode_q = SCAN_IDLE;
      end
      if (mode_q == SCAN_QUOTE) begin
         if (c == quote_q && prev_q != CHAR_BACKSLASH) begin
            run_tokens.push_back(tok(KIND_QUOTE, begin_q, span(begin_q, pos, 1), 1'b0));
            mode_q = SCAN_IDLE;
         end
      end else if (mode_q == SCAN_IDLE) begin
         if (is_oper(c)) begin
            run_tokens.push_back(tok(KIND_OPER, pos, 16'd1, 1'b0));
         end else if (is_blank(c)) begin
            if (c == CHAR_NEWLINE)
               run_tokens.push_back(tok(KIND_NEWLINE, pos, 16'd1, 1'b0));
         end else if (c == CHAR_HASH) begin
            begin_q = pos;
            mode_q  = SCAN_COMMENT;
         end else if (is_quote(c)) begin
            quote_q = c;
            begin_q = pos;
            mode_q  = SCAN_QUOTE;
         end else begin
            begin_q = pos;
            mode_q  = SCAN_WORD;
         end
      end
      if (eol) begin
         // an open quote is dropped here
         if (mode_q == SCAN_WORD)
            run_tokens.push_back(tok(KIND_WORD, begin_q, span(begin_q, pos, 1), 1'b0));
         else if (mode_q == SCAN_COMMENT)
            run_tokens.push_back(tok(KIND_COMMENT, begin_q, span(begin_q, pos, 1), 1'b0));
         clear_scan();
      end else begin
         prev_q = c;
         if (32'(pos_q) < POS_TOP)
            pos_q = pos_q + 16'd1;
      end
      if (run_tokens.size() > 0)
         run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
   endfunction

   function automatic step_row_type row(input logic [7:0] c, input logic eol,
                                        input bit typed, input int count,
                                        input token_type t0, input token_type t1);
      step_row_type r;
      r.char_code   = c;
      r.end_of_line = eol;
      r.typed       = typed;
      r.count       = count;
      r.tok0        = t0;
      r.tok1        = t1;
      return r;
   endfunction

   function automatic logic [7:0] word_byte();
      logic [7:0] c;
      do
         c = 8'($urandom_range(1, 255));
      while (is_blank(c) || is_oper(c) || is_quote(c) || c == CHAR_HASH);
      return c;
   endfunction

   function automatic logic [7:0] oper_byte();
      case ($urandom_range(0, 3))
         0:       return CHAR_PIPE;
         1:       return CHAR_AMP;
         2:       return CHAR_LESS;
         default: return CHAR_GREATER;
      endcase
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 9))
         0:       return CHAR_TAB;
         1:       return CHAR_NEWLINE;
         2:       return CHAR_VTAB;
         3:       return CHAR_FORMFEED;
         4:       return CHAR_RETURN;
         default: return CHAR_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] quote_byte();
      case ($urandom_range(0, 2))
         0:       return CHAR_SQUOTE;
         1:       return CHAR_DQUOTE;
         default: return CHAR_BACKTICK;
      endcase
   endfunction

   // appends one line of pieces, or raw noise bytes when not orderly
   task automatic append_line(input bit orderly);
      int         pieces;
      logic [7:0] q;
      if (!orderly) begin
         repeat ($urandom_range(1, 20))
            line_bytes.push_back(8'($urandom_range(1, 255)));
         return;
      end
      pieces = $urandom_range(1, 8);
      for (int p = 0; p < pieces; p++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               repeat ($urandom_range(1, 6))
                  line_bytes.push_back(word_byte());
            end
            4: line_bytes.push_back(oper_byte());
            5: line_bytes.push_back(blank_byte());
            6, 7: begin
               q = quote_byte();
               line_bytes.push_back(q);
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 4) == 0) begin
                     line_bytes.push_back(CHAR_BACKSLASH);
                     line_bytes.push_back(q);
                  end else begin
                     line_bytes.push_back(8'($urandom_range(1, 255)));
                  end
               end
               // now and then the quote stays open to the end of the line
               if ($urandom_range(0, 7) != 0)
                  line_bytes.push_back(q);
            end
            default: begin
               line_bytes.push_back(CHAR_HASH);
               repeat ($urandom_range(0, 5))
                  line_bytes.push_back(8'($urandom_range(1, 255)));
               return;
            end
         endcase
         if ($urandom_range(0, 3) != 0)
            line_bytes.push_back(blank_byte());
      end
   endtask

   task automatic send_byte(input step_row_type r);
      if (idling && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.char_code   <= r.char_code;
      req_if.end_of_line <= r.end_of_line;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      scan_byte(r.char_code, r.end_of_line);
      if (r.typed) begin
         if (r.count > 0)
            expected_tokens.push_back(r.tok0);
         if (r.count > 1)
            expected_tokens.push_back(r.tok1);
      end else begin
         foreach (run_tokens[i])
            expected_tokens.push_back(run_tokens[i]);
      end
      sent_count++;
   endtask

   task automatic send_line();
      token_type none;
      none = tok(KIND_WORD, 16'd0, 16'd0, 1'b0);
      foreach (line_bytes[i])
         send_byte(row(line_bytes[i], i == line_bytes.size() - 1, 1'b0, 0, none, none));
      line_bytes.delete();
   endtask

   always @(posedge clock) begin : rsp_stall
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_tokens
      token_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_tokens.size() == 0) begin
            $error("token with no request waiting: kind %0d start %0d length %0d",
                   rsp_if.token_kind, rsp_if.token_start, rsp_if.token_length);
            fail_count++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_if.token_kind !== want.token_kind) begin
               $error("token_kind: expected %0d, actual %0d", want.token_kind,
                      rsp_if.token_kind);
               fail_count++;
            end
            if (rsp_if.token_start !== want.token_start) begin
               $error("token_start: expected %0d, actual %0d", want.token_start,
                      rsp_if.token_start);
               fail_count++;
            end
            if (rsp_if.token_length !== want.token_length) begin
               $error("token_length: expected %0d, actual %0d", want.token_length,
                      rsp_if.token_length);
               fail_count++;
            end
            if (rsp_if.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                      rsp_if.last_of_run);
               fail_count++;
            end
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_MAX)
         @(posedge clock);
      $display("shell_line_tokenizer_unit test failed");
      $finish;
   end

   initial begin : stimulus
      step_row_type plan[$];
      token_type none;

      none = tok(KIND_WORD, 16'd0, 16'd0, 1'b0);
      clear_scan();
      idling       = 1'b1;
      sent_count   = 0;
      req_if.valid       <= 1'b0;
      req_if.char_code   <= 8'd0;
      req_if.end_of_line <= 1'b0;

      // operators, blanks, word ending on an operator
      plan.push_back(row(CHAR_PIPE, 1'b0, 1, 1, tok(KIND_OPER, 16'd0, 16'd1, 1'b1), none));
      plan.push_back(row(CHAR_AMP, 1'b0, 1, 1, tok(KIND_OPER, 16'd1, 16'd1, 1'b1), none));
      plan.push_back(row(CHAR_LESS, 1'b0, 1, 1, tok(KIND_OPER, 16'd2, 16'd1, 1'b1), none));
      plan.push_back(row(CHAR_GREATER, 1'b0, 1, 1, tok(KIND_OPER, 16'd3, 16'd1, 1'b1),
                         none));
      plan.push_back(row(CHAR_NEWLINE, 1'b0, 1, 1, tok(KIND_NEWLINE, 16'd4, 16'd1, 1'b1),
                         none));
      plan.push_back(row(CHAR_SPACE, 1'b0, 1, 0, none, none));
      plan.push_back(row("a", 1'b0, 1, 0, none, none));
      plan.push_back(row(8'hFF, 1'b0, 1, 0, none, none));
      plan.push_back(row(CHAR_PIPE, 1'b0, 0, 0, none, none));
      // quote with an escaped closing quote inside
      plan.push_back(row(CHAR_SQUOTE, 1'b0, 0, 0, none, none));
      plan.push_back(row(CHAR_BACKSLASH, 1'b0, 0, 0, none, none));
      plan.push_back(row(CHAR_SQUOTE, 1'b0, 0, 0, none, none));
      plan.push_back(row("x", 1'b0, 0, 0, none, none));
      plan.push_back(row(CHAR_SQUOTE, 1'b0, 0, 0, none, none));
      // comment to end of line
      plan.push_back(row(CHAR_HASH, 1'b0, 0, 0, none, none));
      plan.push_back(row(CHAR_DQUOTE, 1'b0, 0, 0, none, none));
      plan.push_back(row(CHAR_TAB, 1'b0, 0, 0, none, none));
      plan.push_back(row("z", 1'b1, 0, 0, none, none));
      // one-byte line, lowest byte
      plan.push_back(row(8'h01, 1'b1, 1, 1, tok(KIND_WORD, 16'd0, 16'd1, 1'b1), none));
      // open quote dropped at end of line
      plan.push_back(row(CHAR_DQUOTE, 1'b0, 1, 0, none, none));
      plan.push_back(row("q", 1'b1, 1, 0, none, none));
      plan.push_back(row(CHAR_BACKTICK, 1'b0, 0, 0, none, none));
      plan.push_back(row(CHAR_BACKTICK, 1'b0, 0, 0, none, none));
      plan.push_back(row("b", 1'b0, 0, 0, none, none));
      plan.push_back(row(CHAR_VTAB, 1'b0, 0, 0, none, none));
      plan.push_back(row(CHAR_FORMFEED, 1'b0, 0, 0, none, none));
      plan.push_back(row("c", 1'b0, 0, 0, none, none));
      plan.push_back(row(CHAR_RETURN, 1'b1, 0, 0, none, none));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i])
         send_byte(plan[i]);

      while (sent_count < 1400) begin
         append_line($urandom_range(0, 4) != 0);
         send_line();
      end

      idling = 1'b0;
      while (sent_count < 1550) begin
         append_line($urandom_range(0, 4) != 0);
         send_line();
      end
      req_if.valid <= 1'b0;

      while (expected_tokens.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0) begin
         $display("shell_line_tokenizer_unit test passed");
      end else begin
         $display("shell_line_tokenizer_unit test failed");
      end
      $finish;
   end

endmodule
